/* rtl/fbfl_pkg.sv */
// Shared types and constants of the fixed block free list allocator.
package fbfl_pkg;

  localparam int CntW         = 9;
  localparam int SizeW        = 13;
  localparam int OutIdxW      = 8;
  localparam int OffW         = 21;
  localparam int MaxBlockSize = 4096;
  localparam int ApbAddrW     = 3;
  localparam int ApbDataW     = 32;

  localparam logic [CntW-1:0]  BlockCountReset = 9'd256;
  localparam logic [SizeW-1:0] BlockSizeReset  = 13'd64;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK             = 2'd0,
    STATUS_POOL_EMPTY     = 2'd1,
    STATUS_NOT_POOL_BLOCK = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_BLOCK_COUNT = 1'b0,
    REG_BLOCK_SIZE  = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LINK,
    S_SETTLE,
    S_EXEC
  } fsm_e;

  typedef struct packed {
    logic [CntW-1:0]  block_count;
    logic [SizeW-1:0] block_size;
  } cfg_t;

endpackage

/* rtl/fbfl_link_mem.sv */
// Link memory: one write port and one registered read port.
module fbfl_link_mem #(
  parameter int Depth = 256,
  parameter int AddrW = 8,
  parameter int DataW = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fbfl_cfg_regs.sv */
// Configuration register file behind the APB-style port.
module fbfl_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbfl_pkg::ApbAddrW-1:0] paddr,
  input  logic [fbfl_pkg::ApbDataW-1:0] pwdata,
  output logic [fbfl_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output fbfl_pkg::cfg_t                cfg_o
);

  import fbfl_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e reg_sel;
  logic wr_en;

  // Registers sit on word boundaries; the byte lane bits are ignored.
  assign reg_sel = reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_BLOCK_COUNT: cfg_d.block_count = pwdata[CntW-1:0];
        REG_BLOCK_SIZE:  cfg_d.block_size  = pwdata[SizeW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BLOCK_COUNT: prdata = ApbDataW'(cfg_q.block_count);
      REG_BLOCK_SIZE:  prdata = ApbDataW'(cfg_q.block_size);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_count <= BlockCountReset;
      cfg_q.block_size  <= BlockSizeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/fixed_block_free_list_allocator_unit.sv */
// Top level of the fixed block free list allocator.
//
// Requests enter on the in channel (kind_i, block_index_i) and every request
// gives exactly one item on the out channel (status_o, granted_index_o,
// byte_offset_o). An allocate pops the head of the free list; a free pushes
// block_index_i back as the new head. Both channels use valid/stall.
// A request is taken in the idle state and its result is loaded into the output
// register from the exec state once that register is free; no new request is
// taken in between. The alloc path is bound by the registered link memory read.
// The first request after reset first links the pool: one link memory write
// per block of the clamped block_count (1 to NUM_BLOCKS), then a settle
// state in which the read port fetches the new head.
// After reset the list is unlinked, the registers hold their defaults
// (256 blocks of 64 bytes) and the link memory content is not cleared.
// If the receiver stalls, the finished result waits in the output register
// and one more request may be taken; its result waits until the register
// frees up. Configuration is written through the APB-style port; the user must
// write it only while the block is idle, which the block itself does not enforce.
module fixed_block_free_list_allocator_unit #(
  parameter int NUM_BLOCKS   = 256,
  parameter int HEADER_BYTES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [fbfl_pkg::OutIdxW-1:0]  block_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [fbfl_pkg::OutIdxW-1:0]  granted_index_o,
  output logic [fbfl_pkg::OffW-1:0]     byte_offset_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbfl_pkg::ApbAddrW-1:0] paddr,
  input  logic [fbfl_pkg::ApbDataW-1:0] pwdata,
  output logic [fbfl_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  import fbfl_pkg::*;

  localparam int PtrW    = $clog2(NUM_BLOCKS + 1);
  localparam int IdxW    = $clog2(NUM_BLOCKS);
  localparam int StrideW = $clog2(HEADER_BYTES + MaxBlockSize + 1);
  localparam int ProdW   = IdxW + StrideW + 1;
  localparam int CalcW   = (ProdW > OffW) ? ProdW : OffW;
  localparam int CmpW    = (PtrW > CntW) ? PtrW : CntW;
  localparam logic [PtrW-1:0] EndMark = PtrW'(NUM_BLOCKS);

  cfg_t cfg;

  fsm_e             state_q, state_d;
  logic             linked_q, linked_d;
  logic [PtrW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  lnk_q, lnk_d;
  kind_e            kind_q;
  logic [OutIdxW-1:0] idx_q;

  logic               out_valid_q, out_valid_d;
  status_e            status_q, res_status;
  logic [OutIdxW-1:0] granted_q, res_granted;
  logic [OffW-1:0]    offset_q, res_offset;
  logic               out_load, out_free;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [PtrW-1:0] mem_wdata;
  logic [PtrW-1:0] mem_rdata;

  logic [PtrW-1:0]    eff_cnt;
  logic [SizeW-1:0]   eff_size;
  logic [StrideW-1:0] stride;
  logic [CalcW-1:0]   off_full;
  logic               head_empty, free_bad, last_link, in_accept;

  fbfl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The read port always follows the list head, so the successor of the
  // head is ready in the cycle after the head settles.
  fbfl_link_mem #(
    .Depth (NUM_BLOCKS),
    .AddrW (IdxW),
    .DataW (PtrW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (head_q[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    if (cfg.block_count == '0) begin
      eff_cnt = PtrW'(1);
    end else if (CmpW'(cfg.block_count) > CmpW'(NUM_BLOCKS)) begin
      eff_cnt = EndMark;
    end else begin
      eff_cnt = PtrW'(cfg.block_count);
    end
  end

  always_comb begin
    if (cfg.block_size == '0) begin
      eff_size = SizeW'(1);
    end else if (cfg.block_size > SizeW'(MaxBlockSize)) begin
      eff_size = SizeW'(MaxBlockSize);
    end else begin
      eff_size = cfg.block_size;
    end
  end

  assign stride     = StrideW'(HEADER_BYTES) + StrideW'(eff_size);
  assign off_full   = CalcW'(head_q[IdxW-1:0]) * CalcW'(stride) + CalcW'(HEADER_BYTES);
  assign head_empty = head_q >= EndMark;
  assign free_bad   = CmpW'(idx_q) >= CmpW'(eff_cnt);
  assign last_link  = lnk_q == IdxW'(eff_cnt - PtrW'(1));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    linked_d    = linked_q;
    head_d      = head_q;
    lnk_d       = lnk_q;
    mem_we      = 1'b0;
    mem_waddr   = lnk_q;
    mem_wdata   = '0;
    out_load    = 1'b0;
    res_status  = STATUS_OK;
    res_granted = '0;
    res_offset  = '0;
    case (state_q)
      S_IDLE: begin
        lnk_d = '0;
        if (in_valid_i) begin
          state_d = linked_q ? S_EXEC : S_LINK;
        end
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = lnk_q;
        if (last_link) begin
          mem_wdata = EndMark;
          head_d    = '0;
          linked_d  = 1'b1;
          state_d   = S_SETTLE;
        end else begin
          mem_wdata = PtrW'(lnk_q) + PtrW'(1);
          lnk_d     = lnk_q + IdxW'(1);
        end
      end
      S_SETTLE: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (kind_q == KIND_ALLOC) begin
          if (head_empty) begin
            res_status = STATUS_POOL_EMPTY;
          end else begin
            res_granted = OutIdxW'(head_q);
            res_offset  = off_full[OffW-1:0];
          end
        end else if (free_bad) begin
          res_status = STATUS_NOT_POOL_BLOCK;
        end
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (kind_q == KIND_ALLOC) begin
            if (!head_empty) begin
              head_d = mem_rdata;
            end
          end else if (!free_bad) begin
            mem_we    = 1'b1;
            mem_waddr = IdxW'(idx_q);
            mem_wdata = head_q;
            head_d    = PtrW'(idx_q);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      linked_q    <= 1'b0;
      head_q      <= EndMark;
      lnk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      linked_q    <= linked_d;
      head_q      <= head_d;
      lnk_q       <= lnk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_e'(kind_i);
      idx_q  <= block_index_i;
    end
    if (out_load) begin
      status_q  <= res_status;
      granted_q <= res_granted;
      offset_q  <= res_offset;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_index_o = granted_q;
  assign byte_offset_o   = offset_q;

  a_head_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= EndMark)
    else $error("free list head beyond the end mark");

  a_link_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |-> !linked_q)
    else $error("pool linked a second time");

  a_exec_linked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> linked_q)
    else $error("item executed on an unlinked pool");

  a_result_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && out_load) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished item did not reach the output register");

endmodule
